// ===== hw/rtl/tmm_pkg.sv =====
// Package for the thruster mixing matrix: item types, codes and fixed constants.
// Used by tmm_mac_unit and thruster_mixing_matrix; depends on nothing else.
package tmm_pkg;

	localparam int TMM_MAX_MOTORS = 8;
	localparam int TMM_COEF_WIDTH = 16;
	localparam int NUM_COLS       = 12;
	localparam int NUM_AXES       = 6;
	localparam int DEMAND_W       = 16;
	localparam int HALF_W         = DEMAND_W + 1;
	localparam int LEVEL_W        = 24;
	localparam int LEVEL_SHIFT    = 12;
	localparam int LEVEL_MAX      = 8388607;
	localparam int LEVEL_MIN      = -8388608;
	localparam int COUNT_RESET    = 8;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_DRIVE = 2'd1,
		ACT_NULL  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [1:0]                  action;
		logic [2:0]                  coef_motor;
		logic [3:0]                  coef_column;
		logic signed [DEMAND_W-1:0]  coef_value;
		logic signed [DEMAND_W-1:0]  axis_surge;
		logic signed [DEMAND_W-1:0]  axis_sway;
		logic signed [DEMAND_W-1:0]  axis_heave;
		logic signed [DEMAND_W-1:0]  axis_roll;
		logic signed [DEMAND_W-1:0]  axis_pitch;
		logic signed [DEMAND_W-1:0]  axis_yaw;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]                 motor_index;
		logic signed [LEVEL_W-1:0]  motor_level;
		logic                       last_motor;
	} level_item_t;

	typedef struct packed {
		logic wr_en;
		logic issue;
		logic acc_clear;
	} mac_ctl_t;

endpackage

// ===== hw/rtl/tmm_mac_unit.sv =====
// Coefficient memory and shared multiply-accumulate datapath of the mixer.
// Depends on tmm_pkg.
module tmm_mac_unit import tmm_pkg::*; #(
	parameter int MAX_MOTORS = TMM_MAX_MOTORS,
	parameter int COEF_WIDTH = TMM_COEF_WIDTH,
	localparam int DEPTH     = MAX_MOTORS * NUM_COLS,
	localparam int ADDR_W    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mac_ctl_t                  ctl,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic signed [COEF_WIDTH-1:0] wr_data,
	input  logic [ADDR_W-1:0]         rd_addr,
	input  logic signed [HALF_W-1:0]  half,
	output logic                      busy,
	output logic signed [LEVEL_W-1:0] level
);

	localparam int PROD_W = COEF_WIDTH + HALF_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam logic signed [ACC_W-1:0] LVL_HI = ACC_W'(LEVEL_MAX);
	localparam logic signed [ACC_W-1:0] LVL_LO = ACC_W'(LEVEL_MIN);

	logic signed [COEF_WIDTH-1:0] coef_mem [DEPTH];
	logic signed [COEF_WIDTH-1:0] coef_s1;
	logic signed [HALF_W-1:0]     half_s1;
	logic                         vld_s1;
	logic signed [PROD_W-1:0]     prod_s2;
	logic                         vld_s2;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      shifted;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			coef_mem[wr_addr] <= wr_data;
		end
		if (ctl.issue) begin
			coef_s1 <= coef_mem[rd_addr];
			half_s1 <= half;
		end
		prod_s2 <= coef_s1 * half_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
			if (ctl.acc_clear) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// Arithmetic shift floors toward minus infinity, then clamp to 24 bits.
	assign shifted = acc_q >>> LEVEL_SHIFT;
	assign busy    = vld_s1 | vld_s2;

	always_comb begin
		if (shifted > LVL_HI) begin
			level = LEVEL_W'(LEVEL_MAX);
		end else if (shifted < LVL_LO) begin
			level = LEVEL_W'(LEVEL_MIN);
		end else begin
			level = shifted[LEVEL_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/thruster_mixing_matrix.sv =====
// Top level of the thruster mixing matrix: command sequencer, demand split,
// motor count register and output register. Depends on tmm_pkg and tmm_mac_unit.
//
// The block turns six signed axis demands into one saturated level per motor.
// A command transaction with action write stores one coefficient of the
// MAX_MOTORS x 12 mixing matrix when its motor and column are in range and
// produces nothing; the matrix has no reset value, so software must load
// every entry it uses before the first drive command. A drive command splits
// every demand into a positive and a negative half, then runs one shared
// multiplier and accumulator over the twelve columns of each motor row in
// turn, one column per cycle, with the coefficient memory read port and the
// product register in front of the accumulator. Each motor row is read, the
// pipeline drains, and the level is loaded into the output register. A null
// command emits a zero level per motor, one per cycle while the consumer
// takes levels at once. Action code 3 is accepted and dropped. cmd_ready
// stays low while a command is being worked on; the last level of a command
// can still wait in the output register while the next command is taken.
// The motor_count register (cfg_data) is always ready, takes effect on the
// next command, and must only be written while the block is idle; 0 acts as
// 1 and values above MAX_MOTORS act as MAX_MOTORS.
module thruster_mixing_matrix import tmm_pkg::*; #(
	parameter int MAX_MOTORS = TMM_MAX_MOTORS,
	parameter int COEF_WIDTH = TMM_COEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_item_t   cmd,
	output logic        lvl_valid,
	input  logic        lvl_ready,
	output level_item_t lvl,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int DEPTH  = MAX_MOTORS * NUM_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int MOT_W  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
	localparam int CNT_W  = $clog2(MAX_MOTORS + 1);

	seq_state_t state_q, state_nxt;
	mac_ctl_t   ctl;

	logic [3:0]                 count_q;
	logic [CNT_W-1:0]           active;
	logic signed [DEMAND_W-1:0] demand_q [NUM_AXES];
	logic [3:0]                 col_q;
	logic [ADDR_W-1:0]          base_q;
	logic [MOT_W-1:0]           motor_q;
	logic                       null_q;
	logic                       lvl_valid_q;
	level_item_t                lvl_q;

	logic                       cmd_fire;
	logic                       emit_fire;
	logic                       last_col;
	logic                       last_mot;
	logic                       wr_ok;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr;
	logic signed [DEMAND_W-1:0] demand;
	logic signed [HALF_W-1:0]   demand_x;
	logic signed [HALF_W-1:0]   half;
	logic                       mac_busy;
	logic signed [LEVEL_W-1:0]  mac_level;

	// Effective motor count after clamping the register to 1..MAX_MOTORS.
	always_comb begin
		if (count_q == 4'd0) begin
			active = CNT_W'(1);
		end else if ({1'b0, count_q} > 5'(MAX_MOTORS)) begin
			active = CNT_W'(MAX_MOTORS);
		end else begin
			active = CNT_W'(count_q);
		end
	end

	assign cmd_fire  = cmd_valid && cmd_ready;
	assign last_col  = (col_q == 4'(NUM_COLS - 1));
	assign last_mot  = ((CNT_W'(motor_q) + CNT_W'(1)) == active);
	assign wr_ok     = (cmd.coef_column < 4'(NUM_COLS))
	                && ({2'b00, cmd.coef_motor} < 5'(MAX_MOTORS));
	assign wr_addr   = ADDR_W'(ADDR_W'(cmd.coef_motor) * ADDR_W'(NUM_COLS))
	                 + ADDR_W'(cmd.coef_column);
	assign rd_addr   = base_q + ADDR_W'(col_q);
	assign cfg_ready = 1'b1;
	assign lvl_valid = lvl_valid_q;
	assign lvl       = lvl_q;

	// Column 2a takes the positive part of axis a, column 2a+1 the magnitude
	// of a zero or negative demand.
	assign demand   = demand_q[col_q[3:1]];
	assign demand_x = HALF_W'(demand);
	always_comb begin
		if (!col_q[0]) begin
			half = (demand > 0) ? demand_x : '0;
		end else begin
			half = (demand > 0) ? '0 : -demand_x;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && (cmd.action == ACT_DRIVE)) begin
					state_nxt = ST_RUN;
				end else if (cmd_fire && (cmd.action == ACT_NULL)) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_RUN: begin
				if (last_col) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					if (last_mot) begin
						state_nxt = ST_IDLE;
					end else if (null_q) begin
						state_nxt = ST_EMIT;
					end else begin
						state_nxt = ST_RUN;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		cmd_ready     = (state_q == ST_IDLE);
		emit_fire     = (state_q == ST_EMIT) && (!lvl_valid_q || lvl_ready);
		ctl.issue     = (state_q == ST_RUN);
		ctl.acc_clear = emit_fire;
		ctl.wr_en     = cmd_fire && (cmd.action == ACT_WRITE) && wr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= 4'(COUNT_RESET);
			col_q       <= '0;
			base_q      <= '0;
			motor_q     <= '0;
			lvl_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == ST_RUN) begin
				col_q <= last_col ? 4'd0 : col_q + 4'd1;
			end
			if (cmd_fire) begin
				base_q  <= '0;
				motor_q <= '0;
			end else if (emit_fire) begin
				base_q  <= base_q + ADDR_W'(NUM_COLS);
				motor_q <= motor_q + MOT_W'(1);
			end
			if (emit_fire) begin
				lvl_valid_q <= 1'b1;
			end else if (lvl_ready) begin
				lvl_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: demands, command kind and the outgoing level.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			demand_q[0] <= cmd.axis_surge;
			demand_q[1] <= cmd.axis_sway;
			demand_q[2] <= cmd.axis_heave;
			demand_q[3] <= cmd.axis_roll;
			demand_q[4] <= cmd.axis_pitch;
			demand_q[5] <= cmd.axis_yaw;
			null_q      <= (cmd.action == ACT_NULL);
		end
		if (emit_fire) begin
			lvl_q.motor_index <= 3'(motor_q);
			lvl_q.motor_level <= null_q ? '0 : mac_level;
			lvl_q.last_motor  <= last_mot;
		end
	end

	tmm_mac_unit #(
		.MAX_MOTORS (MAX_MOTORS),
		.COEF_WIDTH (COEF_WIDTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (COEF_WIDTH'(cmd.coef_value)),
		.rd_addr (rd_addr),
		.half    (half),
		.busy    (mac_busy),
		.level   (mac_level)
	);

	// A drive command always starts the column sweep on the next cycle.
	a_drive_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && (cmd.action == ACT_DRIVE) |=> (state_q == ST_RUN))
		else $error("drive command did not start the column sweep");

	// The multiply pipeline is empty whenever new commands are taken.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mac_busy)
		else $error("multiply pipeline busy while idle");

	// The column counter never leaves the matrix row.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < 4'(NUM_COLS))
		else $error("column counter out of range");

	// The motor being emitted is always one of the configured motors.
	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (CNT_W'(motor_q) < active))
		else $error("motor counter beyond the configured count");

	// A level is loaded only when the accumulator has settled.
	a_emit_settled: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> !mac_busy)
		else $error("level emitted while products are still in flight");

endmodule

// ===== dv/thruster_mixing_matrix_test.sv =====
// Self-checking testbench for thruster_mixing_matrix: a directed script, then random
// commands with random idling on both channels, every level checked in order.
// Depends on tmm_pkg and the thruster_mixing_matrix RTL.
module thruster_mixing_matrix_test;
	import tmm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 24;

	typedef enum {STEP_CMD, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t kind;
		cmd_item_t  item;
		logic [3:0] count;
		bit         typed;
		int         level;
	} script_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	cmd_item_t   cmd = '0;
	logic        lvl_valid;
	logic        lvl_ready = 1'b0;
	level_item_t lvl;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	// Shadow copy of the mixing matrix and motor count, and the levels still owed.
	logic signed [TMM_COEF_WIDTH-1:0] coef_matrix [TMM_MAX_MOTORS][NUM_COLS];
	logic [3:0]  motor_count_q = 4'(COUNT_RESET);
	level_item_t pending_levels [$];
	int          failure_count = 0;
	bit          calm_sender = 1'b0;
	bit          calm_receiver = 1'b0;
	int          hold_left = 0;

	thruster_mixing_matrix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.lvl_valid (lvl_valid),
		.lvl_ready (lvl_ready),
		.lvl       (lvl),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int active_motor_count();
		if (motor_count_q == 0)
			return 1;
		if (motor_count_q > TMM_MAX_MOTORS)
			return TMM_MAX_MOTORS;
		return int'(motor_count_q);
	endfunction

	function automatic level_item_t level_of(int m, int n, logic signed [LEVEL_W-1:0] level);
		level_item_t r;
		r.motor_index = m[2:0];
		r.motor_level = level;
		r.last_motor  = (m == n - 1);
		return r;
	endfunction

	// Splits the demands into halves and forms the saturated, floored level per motor.
	function automatic void compute_motor_levels(input cmd_item_t c);
		logic signed [DEMAND_W-1:0] demand [NUM_AXES];
		logic signed [HALF_W-1:0]   halves [NUM_COLS];
		logic signed [63:0]         acc;
		int n;
		demand = '{c.axis_surge, c.axis_sway, c.axis_heave, c.axis_roll, c.axis_pitch,
			c.axis_yaw};
		n = active_motor_count();
		for (int a = 0; a < NUM_AXES; a++) begin
			if (demand[a] > 0) begin
				halves[2*a]   = HALF_W'(demand[a]);
				halves[2*a+1] = '0;
			end else begin
				halves[2*a]   = '0;
				halves[2*a+1] = -HALF_W'(demand[a]);
			end
		end
		for (int m = 0; m < n; m++) begin
			acc = '0;
			if (c.action == ACT_DRIVE) begin
				for (int k = 0; k < NUM_COLS; k++)
					acc += coef_matrix[m][k] * halves[k];
			end
			// Arithmetic shift rounds toward minus infinity.
			acc = acc >>> LEVEL_SHIFT;
			if (acc > LEVEL_MAX)
				acc = LEVEL_MAX;
			if (acc < LEVEL_MIN)
				acc = LEVEL_MIN;
			pending_levels.push_back(level_of(m, n, acc[LEVEL_W-1:0]));
		end
	endfunction

	// Called for every accepted command transaction.
	function automatic void apply_command(input cmd_item_t c, input bit typed, input int level);
		int n;
		n = active_motor_count();
		case (c.action)
			ACT_WRITE: begin
				if (c.coef_column < NUM_COLS && c.coef_motor < TMM_MAX_MOTORS)
					coef_matrix[c.coef_motor][c.coef_column] = c.coef_value;
			end
			ACT_UNUSED: begin
			end
			default: begin
				if (typed) begin
					for (int m = 0; m < n; m++)
						pending_levels.push_back(level_of(m, n, level[LEVEL_W-1:0]));
				end else begin
					compute_motor_levels(c);
				end
			end
		endcase
	endfunction

	function automatic logic signed [15:0] pick_signed_word();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh0000;
			1: return 16'sh7FFF;
			2: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic cmd_item_t random_command();
		cmd_item_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			c.action = ACT_DRIVE;
		else if (r < 70)
			c.action = ACT_NULL;
		else if (r < 94)
			c.action = ACT_WRITE;
		else
			c.action = ACT_UNUSED;
		c.coef_motor  = 3'($urandom);
		c.coef_column = 4'($urandom_range(0, 15));
		c.coef_value  = pick_signed_word();
		c.axis_surge  = pick_signed_word();
		c.axis_sway   = pick_signed_word();
		c.axis_heave  = pick_signed_word();
		c.axis_roll   = pick_signed_word();
		c.axis_pitch  = pick_signed_word();
		c.axis_yaw    = pick_signed_word();
		return c;
	endfunction

	function automatic script_step_t cfg_step(input logic [3:0] count);
		script_step_t s;
		s.kind  = STEP_CFG;
		s.item  = '0;
		s.count = count;
		s.typed = 1'b0;
		s.level = 0;
		return s;
	endfunction

	function automatic script_step_t write_step(input int motor, input int column,
		input logic signed [15:0] value);
		script_step_t s;
		s = cfg_step(4'd0);
		s.kind = STEP_CMD;
		s.item = random_command();
		s.item.action      = ACT_WRITE;
		s.item.coef_motor  = motor[2:0];
		s.item.coef_column = column[3:0];
		s.item.coef_value  = value;
		return s;
	endfunction

	function automatic script_step_t cmd_step(input logic [1:0] act,
		input logic signed [15:0] surge, input logic signed [15:0] sway,
		input logic signed [15:0] heave, input logic signed [15:0] roll,
		input logic signed [15:0] pitch, input logic signed [15:0] yaw,
		input bit typed = 1'b0, input int level = 0);
		script_step_t s;
		s = cfg_step(4'd0);
		s.kind = STEP_CMD;
		s.item = random_command();
		s.item.action     = act;
		s.item.axis_surge = surge;
		s.item.axis_sway  = sway;
		s.item.axis_heave = heave;
		s.item.axis_roll  = roll;
		s.item.axis_pitch = pitch;
		s.item.axis_yaw   = yaw;
		s.typed = typed;
		s.level = level;
		return s;
	endfunction

	// Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
	task automatic send_command(input cmd_item_t c, input bit typed = 1'b0, input int level = 0);
		int gap;
		gap = pick_gap(calm_sender);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		apply_command(c, typed, level);
	endtask

	// Writes and unused actions leave no trace in the level queue, so a fixed pause
	// follows the last level before the block is treated as idle.
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_motor_count(input logic [3:0] count);
		wait_for_drain();
		cfg_data  <= count;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		motor_count_q = count;
	endtask

	// Level checker and receiver stall generator.
	always @(posedge clk) begin : level_check
		level_item_t want;
		int r;
		if (arst_n && lvl_valid && lvl_ready) begin
			if (pending_levels.size() == 0) begin
				if (failure_count < REPORT_LIMIT)
					$display("unexpected level: motor %0d level %0d last %0b",
						lvl.motor_index, lvl.motor_level, lvl.last_motor);
				failure_count++;
			end else begin
				want = pending_levels.pop_front();
				if (lvl.motor_index !== want.motor_index
					|| lvl.motor_level !== want.motor_level
					|| lvl.last_motor !== want.last_motor) begin
					if (failure_count < REPORT_LIMIT)
						$display("level mismatch: want %0d/%0d/%0b got %0d/%0d/%0b",
							want.motor_index, want.motor_level, want.last_motor,
							lvl.motor_index, lvl.motor_level, lvl.last_motor);
					failure_count++;
				end
			end
		end
		if (hold_left > 0) begin
			lvl_ready <= 1'b0;
			hold_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (calm_receiver || r < 70) begin
				lvl_ready <= 1'b1;
			end else if (r < 94) begin
				lvl_ready <= 1'b0;
				hold_left = $urandom_range(0, 3);
			end else begin
				lvl_ready <= 1'b0;
				hold_left = $urandom_range(10, 40);
			end
		end
	end

	// About 260 items, even under the longest stalls, finish well under this limit.
	initial begin : watchdog
		#8000000;
		$display("thruster_mixing_matrix test failed");
		$finish;
	end

	initial begin : stimulus
		script_step_t script [$];
		cmd_item_t    c;
		logic [3:0]   phase_counts [RANDOM_PHASES];
		phase_counts = '{4'd3, 4'd8, 4'd1, 4'd6, 4'd2, 4'd7};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every matrix entry is loaded before the first drive command.
		for (int m = 0; m < TMM_MAX_MOTORS; m++) begin
			for (int k = 0; k < NUM_COLS; k++) begin
				c = random_command();
				c.action      = ACT_WRITE;
				c.coef_motor  = m[2:0];
				c.coef_column = k[3:0];
				send_command(c);
			end
		end

		// Directed script: single motor corner cases first, then count extremes.
		script.push_back(cfg_step(4'd1));
		script.push_back(write_step(0, 1, 16'sh8000));
		script.push_back(cmd_step(ACT_DRIVE, 16'sh8000, 0, 0, 0, 0, 0, 1'b1, -262144));
		script.push_back(write_step(0, 0, 16'sh7FFF));
		script.push_back(cmd_step(ACT_DRIVE, 16'sh7FFF, 0, 0, 0, 0, 0));
		// A tiny negative sum must floor to -1, not truncate to 0.
		script.push_back(write_step(0, 0, -16'sd1));
		script.push_back(cmd_step(ACT_DRIVE, 16'sd1, 0, 0, 0, 0, 0, 1'b1, -1));
		script.push_back(cmd_step(ACT_NULL, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word(), 1'b1, 0));
		script.push_back(cmd_step(ACT_UNUSED, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word()));
		// Columns past the matrix are dropped; the next drive shows row 0 unchanged.
		script.push_back(write_step(0, 12, 16'sh1234));
		script.push_back(write_step(0, 15, 16'sh8000));
		script.push_back(cmd_step(ACT_DRIVE, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 16'sh7FFF, 16'sh8000));
		script.push_back(cfg_step(4'd8));
		script.push_back(cmd_step(ACT_DRIVE, 0, 0, 0, 0, 0, 0, 1'b1, 0));
		script.push_back(cmd_step(ACT_DRIVE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		script.push_back(cmd_step(ACT_DRIVE, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000));
		script.push_back(cmd_step(ACT_NULL, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 0));
		// A count of zero acts as one motor, counts past the maximum act as the maximum.
		script.push_back(cfg_step(4'd0));
		script.push_back(cmd_step(ACT_DRIVE, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word()));
		script.push_back(cfg_step(4'd9));
		script.push_back(cmd_step(ACT_DRIVE, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word()));
		script.push_back(cfg_step(4'd15));
		script.push_back(cmd_step(ACT_NULL, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word(), 1'b1, 0));
		script.push_back(cfg_step(4'd5));
		script.push_back(cmd_step(ACT_DRIVE, pick_signed_word(), pick_signed_word(),
			pick_signed_word(), pick_signed_word(), pick_signed_word(),
			pick_signed_word()));

		foreach (script[i]) begin
			if (script[i].kind == STEP_CFG)
				write_motor_count(script[i].count);
			else
				send_command(script[i].item, script[i].typed, script[i].level);
		end

		// Random phases, each under its own motor count; some phases run without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_motor_count(phase_counts[p]);
			calm_sender   = ($urandom_range(0, 3) == 0);
			calm_receiver = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_command(random_command());
		end

		calm_sender   = 1'b0;
		calm_receiver = 1'b0;
		wait_for_drain();
		if (failure_count == 0 && pending_levels.size() == 0)
			$display("thruster_mixing_matrix test passed");
		else
			$display("thruster_mixing_matrix test failed");
		$finish;
	end

endmodule
